>>> hdl/tdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  // first odd trial divisor
  localparam int FIRST_DIVISOR = 3;

endpackage

`default_nettype wire

>>> hdl/trial_division_prime_test_core.sv
// channel  ports                                        direction
// in       in_valid, in_ready, in_number,               request in
//          in_float_tagged
// out      out_valid, out_ready, out_prime_flag         request out
//
// one request at a time; in_ready is high only while the sequencer is idle.
// tagged, negative, 0, 1, 2 and even values skip the divider and go straight to ST_FIN.
// odd values run a restoring divider for each trial divisor, one bit per cycle in
// ST_DIV, followed by a check in ST_CHECK.
// the next request is taken while the result waits in the output register.
// rst_n is synchronous, active low, and clears only control state.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test_core
  import tdpt_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire signed [DATA_WIDTH-1:0] in_number,
  input  wire                         in_float_tagged,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_prime_flag
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  state_t          state_r, state_nxt;
  logic [W-1:0]    val_r, val_nxt;
  logic [W-1:0]    div_r, div_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    quo_r, quo_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            flag_r, flag_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_flag_r, out_flag_nxt;

  logic [W-1:0]    in_val;
  logic            in_early;
  logic            in_early_flag;
  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            accept;

  assign in_val   = $unsigned(in_number);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // cases decided without division
  assign in_early = in_float_tagged || in_val[W-1] ||
                    (in_val <= W'(1)) || (in_val == W'(2)) || !in_val[0];
  assign in_early_flag = !in_float_tagged && (in_val == W'(2));

  // shared restoring divider step
  assign shifted = {acc_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    div_nxt       = div_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt = in_val;
          if (in_early) begin
            flag_nxt  = in_early_flag;
            state_nxt = ST_FIN;
          end else begin
            div_nxt   = W'(FIRST_DIVISOR);
            acc_nxt   = '0;
            quo_nxt   = in_val;
            cnt_nxt   = CW'(W);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!diff[W]) begin
          acc_nxt = diff[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = shifted[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // loop bound d <= v / d, then the remainder
        if (div_r > quo_r) begin
          flag_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else if (acc_r == '0) begin
          flag_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          div_nxt   = div_r + W'(1);
          acc_nxt   = '0;
          quo_nxt   = val_r;
          cnt_nxt   = CW'(W);
          state_nxt = ST_DIV;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = flag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    div_r      <= div_nxt;
    acc_r      <= acc_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    flag_r     <= flag_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_prime_flag = out_flag_r;

  a_tagged_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_float_tagged |=> (state_r == ST_FIN) && !flag_r)
    else $error("tagged operand did not finish with flag 0");

  a_two_is_prime: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_float_tagged && (in_val == W'(2)) |=> (state_r == ST_FIN) && flag_r)
    else $error("value 2 not reported prime");

  a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) || (state_r == ST_CHECK) |-> div_r >= W'(FIRST_DIVISOR))
    else $error("trial divisor below first divisor");

  a_remainder_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> acc_r < div_r)
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

>>> verif/trial_division_prime_test_checker.sv
`timescale 1ns / 1ps

module trial_division_prime_test_checker
  import tdpt_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  wire [DATA_WIDTH-1:0] in_number,
  input  wire                  in_float_tagged,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  wire                  out_prime_flag,
  output int                   fail_count,
  output int                   pending
);

  logic prime_flag_due[$];

  function automatic logic prime_by_trial(input logic [DATA_WIDTH-1:0] n, input logic is_float);
    logic [DATA_WIDTH-1:0] d;
    if (is_float) return 1'b0;
    // negative values fall under "one or less"
    if (n[DATA_WIDTH-1]) return 1'b0;
    if (n <= 1) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    // d <= n / d is the exact i*i <= n bound without overflow
    for (d = DATA_WIDTH'(FIRST_DIVISOR); d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      prime_flag_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (prime_flag_due.size() == 0) begin
          $error("out_prime_flag: no request outstanding, actual %0b", out_prime_flag);
          fail_count <= fail_count + 1;
        end else begin
          want = prime_flag_due.pop_front();
          if (out_prime_flag !== want) begin
            $error("out_prime_flag: expected %0b, actual %0b", want, out_prime_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        prime_flag_due.push_back(prime_by_trial(in_number, in_float_tagged));
    end
    pending <= prime_flag_due.size();
  end

endmodule

>>> verif/trial_division_prime_test_core_test.sv
`timescale 1ns / 1ps

module trial_division_prime_test_core_test;

  localparam int DW = 32;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  wire           in_ready;
  logic [DW-1:0] in_number = '0;
  logic          in_float_tagged = 1'b0;
  wire           out_valid;
  logic          out_ready = 1'b0;
  wire           out_prime_flag;

  int   fail_count;
  int   pending;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  trial_division_prime_test_core #(
    .DATA_WIDTH(DW)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number      (in_number),
    .in_float_tagged(in_float_tagged),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prime_flag (out_prime_flag)
  );

  trial_division_prime_test_checker #(
    .DATA_WIDTH(DW)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number      (in_number),
    .in_float_tagged(in_float_tagged),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prime_flag (out_prime_flag),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever hold_tog flips
  always @(negedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_request(input logic [DW-1:0] num, input logic is_float);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_number       <= num;
    in_float_tagged <= is_float;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // odd values are kept mostly small, since the divider walks every trial divisor
  task automatic pick_request(input bit cheap, output logic [DW-1:0] num, output logic is_float);
    int          sel;
    logic [31:0] r;
    sel      = cheap ? $urandom_range(0, 44) : $urandom_range(0, 99);
    r        = $urandom;
    is_float = 1'b0;
    if (sel < 10) begin
      num      = r;
      is_float = 1'b1;
    end else if (sel < 20) begin
      num = {1'b1, r[30:0]};
    end else if (sel < 30) begin
      num = {1'b0, r[30:1], 1'b0};
    end else if (sel < 45) begin
      num = DW'($urandom_range(0, 64));
    end else if (sel < 85) begin
      num = DW'($urandom_range(1, 2047) * 2 + 1);
    end else if (sel < 93) begin
      num = DW'($urandom_range(1, 32767) * 2 + 1);
    end else if (sel < 97) begin
      // large odd composite with a small factor
      num = DW'({r[27:0], 1'b1} * (2 * $urandom_range(1, 3) + 1));
    end else begin
      num = DW'($urandom_range(1, 524287) * 2 + 1);
    end
  endtask

  initial begin
    logic [DW-1:0] num;
    logic          is_float;
    int            k;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(32'd0, 1'b0);
    send_request(32'd1, 1'b0);
    send_request(32'd2, 1'b0);
    send_request(32'd3, 1'b0);
    send_request(32'd4, 1'b0);
    send_request(32'd5, 1'b0);
    send_request(32'd9, 1'b0);
    send_request(32'd121, 1'b0);
    send_request(32'd169, 1'b0);
    send_request(32'd2, 1'b1);
    send_request(32'd7, 1'b1);
    send_request(32'd0, 1'b1);
    send_request(32'h7fff_ffff, 1'b1);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    send_request(32'h7fff_fffe, 1'b0);
    send_request(32'h7fff_fffd, 1'b0);
    send_request(32'h7fff_fffb, 1'b0);
    send_request(32'd65535, 1'b0);
    send_request(32'd65521, 1'b0);
    send_request(32'd1000003, 1'b0);

    // sender waits for every outstanding request to complete
    drain_results();

    // long receiver hold-off while requests keep coming
    hold_tog <= ~hold_tog;
    for (k = 0; k < 12; k++) begin
      pick_request(1'b1, num, is_float);
      send_request(num, is_float);
    end

    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
        default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
      endcase
      repeat (17) begin
        pick_request(1'b0, num, is_float);
        send_request(num, is_float);
      end
    end

    drain_results();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
